### rtl/core/tno_pkg.sv
package tno_pkg;

  // Telnet command bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  // Option codes
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;

  // ASCII characters of the terminal type name
  localparam logic [7:0] CH_V    = 8'h76;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam int unsigned TTYPE_LEN = 10;
  localparam int unsigned IDX_W     = 4;

  typedef enum logic [3:0] {
    PS_NORMAL = 4'd0,
    PS_IAC    = 4'd1,
    PS_DO     = 4'd2,
    PS_DONT   = 4'd3,
    PS_WILL   = 4'd4,
    PS_WONT   = 4'd5,
    PS_SB     = 4'd6,
    PS_SB_IAC = 4'd7,
    PS_SB_TT  = 4'd8
  } parse_state_t;

  // Kind of work handed from the parser to the expander
  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_REPLY = 2'd1,
    CMD_TTYPE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] verb;   // second byte of a three-byte reply
    logic [7:0] opt;    // data byte, or option byte of a reply
    logic       echo;   // echo flag after the causing byte
  } cmd_t;

  // Terminal type reply: IAC SB TERMTYPE v t 1 0 0 IAC SE
  function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = B_IAC;
      4'd1:    b = B_SB;
      4'd2:    b = OPT_TTYPE;
      4'd3:    b = CH_V;
      4'd4:    b = CH_T;
      4'd5:    b = CH_ONE;
      4'd6:    b = CH_ZERO;
      4'd7:    b = CH_ZERO;
      4'd8:    b = B_IAC;
      4'd9:    b = B_SE;
      default: b = B_IAC;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/telnet_option_negotiator.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// input     | push / full        | rx_byte
// results   | pop / empty        | out_byte, to_server, last, local_echo
//
// A byte is accepted in any cycle in which the command queue has room, so a
// stream of plain bytes passes at one transaction per cycle while pop is held,
// each registered in the queue first. A reply is three result bytes and the
// terminal type reply ten, set by the expander, one byte per cycle while popped.
// While a burst is drained, later bytes keep being parsed until the queue of
// DEPTH commands fills; full then holds off the sender.
// Reset (rst, synchronous) returns the parser to normal data, clears the
// echo flag and empties the queue.
module telnet_option_negotiator #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       to_server,
  output logic       last,
  output logic       local_echo
);
  import tno_pkg::*;

  // The front end parses each accepted byte, keeps the IAC sequence position
  // and the echo flag, and produces at most one command per byte. A byte
  // that yields nothing, such as one inside a subnegotiation, leaves the
  // queue alone.
  logic accept;
  logic cmd_valid;
  cmd_t cmd_in;

  // Between the two halves sits a short queue of commands, so that the
  // parser can run ahead while the expander is stalled on the result side.
  logic cmd_present;
  logic q_empty;
  logic cmd_done;
  cmd_t cmd_head;

  assign accept      = push && !full;
  assign cmd_present = !q_empty;
  assign empty       = q_empty;

  tno_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_byte   (rx_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  tno_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_valid),
    .wr_data (cmd_in),
    .full    (full),
    .rd      (cmd_done),
    .rd_data (cmd_head),
    .empty   (q_empty)
  );

  // The back end turns the command at the head of the queue into result
  // bytes, one per transaction, and releases the command with the last one.
  tno_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_present (cmd_present),
    .cmd         (cmd_head),
    .pop         (pop),
    .cmd_done    (cmd_done),
    .out_byte    (out_byte),
    .to_server   (to_server),
    .last        (last),
    .local_echo  (local_echo)
  );

endmodule

### rtl/core/tno_front.sv
module tno_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          cmd_valid,
  output tno_pkg::cmd_t cmd
);
  import tno_pkg::*;

  parse_state_t state, state_next;
  logic         echo, echo_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_NORMAL;
      echo  <= 1'b0;
    end else if (in_valid) begin
      state <= state_next;
      echo  <= echo_next;
    end
  end

  always_comb begin
    state_next = PS_NORMAL;
    echo_next  = echo;
    cmd_valid  = 1'b0;
    cmd.kind   = CMD_DATA;
    cmd.verb   = in_byte;
    cmd.opt    = in_byte;
    unique case (state)
      PS_IAC: begin
        priority if (in_byte == B_IAC) begin
          cmd_valid = in_valid;
        end else if (in_byte == B_DO) begin
          state_next = PS_DO;
        end else if (in_byte == B_DONT) begin
          state_next = PS_DONT;
        end else if (in_byte == B_WILL) begin
          state_next = PS_WILL;
        end else if (in_byte == B_WONT) begin
          state_next = PS_WONT;
        end else if (in_byte == B_SB) begin
          state_next = PS_SB;
        end else begin
          state_next = PS_NORMAL;
        end
      end
      PS_DO: begin
        cmd_valid = in_valid;
        cmd.kind  = CMD_REPLY;
        if (in_byte == OPT_TTYPE || in_byte == OPT_ECHO) begin
          cmd.verb = B_WILL;
        end else begin
          cmd.verb = B_WONT;
        end
        if (in_byte == OPT_ECHO) begin
          echo_next = 1'b1;
        end
      end
      PS_WILL: begin
        cmd_valid = in_valid;
        cmd.kind  = CMD_REPLY;
        if (in_byte == OPT_ECHO || in_byte == OPT_TTYPE || in_byte == OPT_SGA) begin
          cmd.verb = B_DO;
        end else begin
          cmd.verb = B_DONT;
        end
        if (in_byte == OPT_ECHO) begin
          echo_next = 1'b0;
        end
      end
      PS_DONT, PS_WONT: begin
        state_next = PS_NORMAL;
      end
      PS_SB: begin
        priority if (in_byte == B_IAC) begin
          state_next = PS_SB_IAC;
        end else if (in_byte == OPT_TTYPE) begin
          state_next = PS_SB_TT;
        end else begin
          state_next = PS_SB;
        end
      end
      PS_SB_IAC: begin
        state_next = (in_byte == B_SE) ? PS_NORMAL : PS_SB;
      end
      PS_SB_TT: begin
        cmd_valid  = in_valid;
        cmd.kind   = CMD_TTYPE;
        state_next = PS_SB;
      end
      default: begin
        // Normal data, and any code that is never entered
        if (in_byte == B_IAC) begin
          state_next = PS_IAC;
        end else begin
          cmd_valid = in_valid;
        end
      end
    endcase
    cmd.echo = echo_next;
  end

endmodule

### rtl/core/tno_queue.sv
module tno_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  tno_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd,
  output tno_pkg::cmd_t rd_data,
  output logic          empty
);
  import tno_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/tno_back.sv
module tno_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_present,
  input  tno_pkg::cmd_t cmd,
  input  logic          pop,
  output logic          cmd_done,
  output logic [7:0]    out_byte,
  output logic          to_server,
  output logic          last,
  output logic          local_echo
);
  import tno_pkg::*;

  localparam logic [IDX_W-1:0] LAST_DATA  = IDX_W'(0);
  localparam logic [IDX_W-1:0] LAST_REPLY = IDX_W'(2);
  localparam logic [IDX_W-1:0] LAST_TTYPE = IDX_W'(TTYPE_LEN - 1);

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;
  logic             take;

  always_comb begin
    unique case (cmd.kind)
      CMD_REPLY: last_idx = LAST_REPLY;
      CMD_TTYPE: last_idx = LAST_TTYPE;
      default:   last_idx = LAST_DATA;
    endcase
  end

  always_comb begin
    unique case (cmd.kind)
      CMD_REPLY: begin
        unique case (idx)
          4'd0:    out_byte = B_IAC;
          4'd1:    out_byte = cmd.verb;
          default: out_byte = cmd.opt;
        endcase
      end
      CMD_TTYPE: out_byte = ttype_byte(idx);
      default:   out_byte = cmd.opt;
    endcase
  end

  assign to_server  = (cmd.kind != CMD_DATA);
  assign last       = (idx == last_idx);
  assign local_echo = cmd.echo;
  assign take       = cmd_present && pop;
  assign cmd_done   = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

endmodule

### rtl/core/tno_checker.sv
module tno_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       to_server,
  input logic       last,
  input logic       local_echo
);

  // Nothing is waiting in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results pending after reset");

  // The command queue cannot be full and empty at once.
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !(full && empty))
    else $error("full and empty together");

  // A byte for the terminal is always a burst of its own.
  a_data_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && !to_server) |-> last)
    else $error("terminal byte not marked last");

  // Inside a reply burst the following bytes stay bound for the server and
  // carry the same echo flag.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=>
      (!empty && to_server && local_echo == $past(local_echo)))
    else $error("reply burst broken");

  // A result that is not taken holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind telnet_option_negotiator tno_checker u_tno_checker (.*);

### bench/telnet_option_negotiator_checker.sv
module telnet_option_negotiator_checker
  import tno_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] rx_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       to_server,
  input  logic       last,
  input  logic       local_echo,
  output int         fail_count,
  output int         outstanding,
  output int         beats_checked
);

  typedef struct {
    logic [7:0] data;
    logic       srv;
    logic       fin;
    logic       echo;
  } out_beat_t;

  parse_state_t ps        = PS_NORMAL;
  logic         echo_flag = 1'b0;
  out_beat_t    beat_q [$];
  logic [7:0]   ttype_seq [TTYPE_LEN];

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    beats_checked = 0;
    ttype_seq = '{B_IAC, B_SB, OPT_TTYPE, CH_V, CH_T, CH_ONE, CH_ZERO, CH_ZERO,
                  B_IAC, B_SE};
  end

  // Advances the parser by one received byte and queues the bytes it answers with.
  task automatic negotiate_byte(input logic [7:0] c);
    logic [7:0] burst [$];
    logic       srv;
    out_beat_t  beat;
    srv = 1'b1;
    case (ps)
      PS_IAC: begin
        ps  = PS_NORMAL;
        srv = 1'b0;
        if (c == B_IAC) burst.push_back(B_IAC);
        else if (c == B_DO) ps = PS_DO;
        else if (c == B_DONT) ps = PS_DONT;
        else if (c == B_WILL) ps = PS_WILL;
        else if (c == B_WONT) ps = PS_WONT;
        else if (c == B_SB) ps = PS_SB;
      end
      PS_DO: begin
        burst.push_back(B_IAC);
        if (c == OPT_TTYPE) begin
          burst.push_back(B_WILL);
        end else if (c == OPT_ECHO) begin
          burst.push_back(B_WILL);
          echo_flag = 1'b1;
        end else begin
          burst.push_back(B_WONT);
        end
        burst.push_back(c);
        ps = PS_NORMAL;
      end
      PS_WILL: begin
        burst.push_back(B_IAC);
        if (c == OPT_ECHO) begin
          burst.push_back(B_DO);
          echo_flag = 1'b0;
        end else if (c == OPT_TTYPE || c == OPT_SGA) begin
          burst.push_back(B_DO);
        end else begin
          burst.push_back(B_DONT);
        end
        burst.push_back(c);
        ps = PS_NORMAL;
      end
      PS_DONT, PS_WONT: ps = PS_NORMAL;
      PS_SB: begin
        if (c == B_IAC) ps = PS_SB_IAC;
        else if (c == OPT_TTYPE) ps = PS_SB_TT;
      end
      PS_SB_IAC: ps = (c == B_SE) ? PS_NORMAL : PS_SB;
      PS_SB_TT: begin
        foreach (ttype_seq[k]) burst.push_back(ttype_seq[k]);
        ps = PS_SB;
      end
      default: begin
        srv = 1'b0;
        ps  = PS_NORMAL;
        if (c == B_IAC) ps = PS_IAC;
        else burst.push_back(c);
      end
    endcase
    foreach (burst[k]) begin
      beat.data = burst[k];
      beat.srv  = srv;
      beat.fin  = (k == burst.size() - 1);
      beat.echo = echo_flag;
      beat_q.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (rst) begin
      ps        = PS_NORMAL;
      echo_flag = 1'b0;
      beat_q.delete();
    end else begin
      if (pop && !empty) begin
        if (beat_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: out_byte=%02h to_server=%0b last=%0b echo=%0b",
                     out_byte, to_server, last, local_echo);
        end else begin
          exp_beat = beat_q.pop_front();
          beats_checked++;
          if ({out_byte, to_server, last, local_echo} !==
              {exp_beat.data, exp_beat.srv, exp_beat.fin, exp_beat.echo}) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                       exp_beat.data, exp_beat.srv, exp_beat.fin, exp_beat.echo,
                       out_byte, to_server, last, local_echo);
          end
        end
      end
      if (push && !full) negotiate_byte(rx_byte);
    end
    outstanding = beat_q.size();
  end

endmodule

### bench/telnet_option_negotiator_tb.sv
module telnet_option_negotiator_tb;
  import tno_pkg::*;

  // A NOP command byte, which the parser swallows after IAC.
  localparam logic [7:0] B_NOP = 8'd241;
  localparam int RANDOM_ITEMS = 380;

  logic       clk     = 1'b0;
  logic       rst     = 1'b1;
  logic       push    = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       pop     = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       to_server;
  logic       last;
  logic       local_echo;

  int fail_count;
  int outstanding;
  int beats_checked;

  logic [7:0] rx_q [$];
  logic [7:0] directed_seq [26];
  int         directed_len;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  telnet_option_negotiator i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .to_server (to_server),
    .last      (last),
    .local_echo(local_echo)
  );

  telnet_option_negotiator_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .to_server    (to_server),
    .last         (last),
    .local_echo   (local_echo),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .beats_checked(beats_checked)
  );

  // Idle gap before the next transaction. In a calm stretch there is none at all;
  // otherwise over half are none, most of the rest are short and a few are long enough
  // to let the other side run dry or fill up.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Option byte for a negotiation: mostly the options the client knows about,
  // sometimes anything at all.
  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 3))
      0:       return OPT_ECHO;
      1:       return OPT_SGA;
      2:       return OPT_TTYPE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Appends one random stretch of the server stream. Most of it is well-formed
  // Telnet with random content, so that the deeper parser states are reached;
  // the rest is raw noise, which also breaks sequences off part way.
  task automatic add_random_sequence();
    int kind;
    int parts;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      rx_q.push_back(8'($urandom_range(0, 254)));
    end else if (kind < 37) begin
      rx_q.push_back(B_IAC);
      rx_q.push_back(B_IAC);
    end else if (kind < 52) begin
      rx_q.push_back(B_IAC);
      rx_q.push_back(B_DO);
      rx_q.push_back(pick_option());
    end else if (kind < 67) begin
      rx_q.push_back(B_IAC);
      rx_q.push_back(B_WILL);
      rx_q.push_back(pick_option());
    end else if (kind < 75) begin
      rx_q.push_back(B_IAC);
      rx_q.push_back($urandom_range(0, 1) ? B_DONT : B_WONT);
      rx_q.push_back(pick_option());
    end else if (kind < 80) begin
      // Any other command after IAC is dropped on the floor.
      rx_q.push_back(B_IAC);
      rx_q.push_back(8'($urandom_range(0, 249)));
    end else if (kind < 92) begin
      // A subnegotiation whose body mixes ordinary bytes, terminal type requests
      // (the byte after TERMTYPE is eaten whatever it is) and IAC escapes that
      // do not close the body.
      rx_q.push_back(B_IAC);
      rx_q.push_back(B_SB);
      parts = $urandom_range(0, 4);
      repeat (parts) begin
        case ($urandom_range(0, 2))
          0: rx_q.push_back(8'($urandom_range(25, 254)));
          1: begin
            rx_q.push_back(OPT_TTYPE);
            rx_q.push_back(8'($urandom_range(0, 255)));
          end
          default: begin
            rx_q.push_back(B_IAC);
            rx_q.push_back(8'($urandom_range(241, 255)));
          end
        endcase
      end
      rx_q.push_back(B_IAC);
      rx_q.push_back(B_SE);
    end else begin
      repeat ($urandom_range(1, 4)) rx_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: pop is raised after a random gap and then held until a
  // transaction has gone through, so the block sees stalls at every point of
  // a reply burst.
  initial begin
    int gap;
    bit calm;
    calm = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = pick_gap(calm);
      if (gap > 0) begin
        @(negedge clk) pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Input side and verdict.
  initial begin
    int gap;
    bit calm;
    int pause_at;
    calm = 1'b0;

    // Directed part: plain data, the escaped 255, DO ECHO (sets the echo flag),
    // WILL for an unknown option 255, WILL ECHO (clears it again), a WONT that
    // is swallowed, a NOP that is swallowed, and a subnegotiation in which a
    // terminal type request is followed by IAC (eaten, reply sent), then an
    // ordinary body byte, an IAC escape that does not end the body, and IAC SE.
    directed_seq = '{8'h00,
                     B_IAC, B_IAC,
                     B_IAC, B_DO, OPT_ECHO,
                     B_IAC, B_WILL, 8'hFF,
                     B_IAC, B_WILL, OPT_ECHO,
                     B_IAC, B_WONT, 8'h00,
                     B_IAC, B_NOP,
                     B_IAC, B_SB, OPT_TTYPE, B_IAC, 8'd7, B_IAC, 8'd5, B_IAC, B_SE};
    foreach (directed_seq[k]) rx_q.push_back(directed_seq[k]);
    directed_len = rx_q.size();
    while (rx_q.size() < directed_len + RANDOM_ITEMS) add_random_sequence();
    pause_at = directed_len + RANDOM_ITEMS / 2;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (rx_q[k]) begin
      // Halfway through, the sender holds back until the block has drained
      // completely, so the parser is picked up again from an idle pipeline.
      if (k == pause_at) begin
        @(negedge clk) push <= 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = pick_gap(calm);
      if (gap > 0) begin
        @(negedge clk) push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) begin
        push    <= 1'b1;
        rx_byte <= rx_q[k];
      end
      do @(posedge clk); while (full);
    end
    @(negedge clk) push <= 1'b0;

    // Let every expected byte come out, then give the block a little longer
    // in case it produces something it should not.
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d received bytes (%0d directed) and checked %0d result transactions",
             rx_q.size(), directed_len, beats_checked);
    $display("negotiation verbs, IAC escapes, swallowed commands and terminal type requests");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("timeout with %0d results still expected", outstanding);
    $display("status: fail");
    $finish;
  end

endmodule
